/* hdl/vstc_pkg.sv */
package vstc_pkg;

  // Width of one flag set and the bit positions inside it
  localparam int FLAG_W = 7;
  localparam int F_SYNC_HI_PULSE  = 0;
  localparam int F_BLACK_PULSE    = 1;
  localparam int F_SYNC_LO_BACK   = 2;
  localparam int F_BLACK_BACK     = 3;
  localparam int F_SYNC_LO_ACTIVE = 4;
  localparam int F_SYNC_LO_FRONT  = 5;
  localparam int F_BLACK_FRONT    = 6;

  // Datapath widths, sized for active areas up to 2048
  localparam int TIME_W = 32;  // line and frame time in ns
  localparam int TOL_W  = 16;  // Q0.16 tolerance
  localparam int CNT_W  = 13;  // sum of pixel or line counts
  localparam int LINE_W = 21;  // horizontal edges and line length in ns
  localparam int SUM_W  = 34;  // vertical edges in ns
  localparam int MA_W   = 32;  // multiplier operand a
  localparam int MB_W   = 16;  // multiplier operand b
  localparam int MP_W   = MA_W + MB_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_NS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_SYNC_PX     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_BACK_PX     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H_FRONT_PX    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V_SYNC_LINES  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V_BACK_LINES  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_V_FRONT_LINES = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 4'd7;

  // One phase classification request: time, tolerance product, period edges
  typedef struct packed {
    logic              sync;
    logic              black;
    logic [TIME_W-1:0] t;
    logic [MP_W-1:0]   tp;   // t * tolerance_frac
    logic [SUM_W-1:0]  e1;   // end of pulse
    logic [SUM_W-1:0]  e2;   // end of back porch
    logic [SUM_W-1:0]  e3;   // end of active area
    logic [SUM_W-1:0]  e4;   // end of front porch
  } phase_req_t;

endpackage

/* hdl/vstc_mul.sv */
module vstc_mul import vstc_pkg::*; (
  input  logic            clk,
  input  logic [MA_W-1:0] mul_a,
  input  logic [MB_W-1:0] mul_b,
  output logic [MP_W-1:0] mul_p
);

  logic [MP_W-1:0] prod_r;

  // Registered 32x16 product, one result per cycle
  always_ff @(posedge clk) begin
    prod_r <= MP_W'(mul_a) * MP_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

/* hdl/vstc_phase.sv */
module vstc_phase import vstc_pkg::*; (
  input  phase_req_t        req,
  output logic [FLAG_W-1:0] flags
);

  localparam int PW = SUM_W + 17;

  logic [PW-1:0] t_sh;
  logic [PW-1:0] hi;
  logic [PW-1:0] lo;
  logic [PW-1:0] e1_sh;
  logic [PW-1:0] e2_sh;
  logic [PW-1:0] e3_sh;
  logic [PW-1:0] e4_sh;

  // t*(1+tol) and t*(1-tol) in Q.16, edges scaled to match
  always_comb begin
    t_sh  = PW'({req.t, 16'b0});
    hi    = t_sh + PW'(req.tp);
    lo    = t_sh - PW'(req.tp);
    e1_sh = PW'({req.e1, 16'b0});
    e2_sh = PW'({req.e2, 16'b0});
    e3_sh = PW'({req.e3, 16'b0});
    e4_sh = PW'({req.e4, 16'b0});
  end

  // Phase sort and level checks
  always_comb begin
    flags = '0;
    if (hi < e1_sh) begin
      flags[F_SYNC_HI_PULSE] = req.sync;
      flags[F_BLACK_PULSE]   = req.black;
    end else if (hi < e2_sh) begin
      flags[F_SYNC_LO_BACK]  = !req.sync;
      flags[F_BLACK_BACK]    = req.black;
    end else if (lo > e2_sh && hi < e3_sh) begin
      flags[F_SYNC_LO_ACTIVE] = !req.sync;
    end else if (lo > e3_sh && hi < e4_sh) begin
      flags[F_SYNC_LO_FRONT] = !req.sync;
      flags[F_BLACK_FRONT]   = req.black;
    end
  end

endmodule

/* hdl/vga_sync_timing_check_capture.sv */
// VGA sync timing checker with pixel capture.
// Input channel: one sample per item (hsync, vsync, 3-bit RGB, ns since the
// previous sample) on in_valid / in_stall. Result channel: one item per
// sample on out_valid / out_stall, carrying the end-of-frame flag report and
// an optional pixel write (column, row, colour scaled to 8 bits).
// Configuration: cfg_valid / cfg_ready with a register index and data; write
// only while no sample is in flight. cfg_ready is always high.
// The block takes one sample at a time: in_stall stays high while a sample
// runs through the multiplier steps, the vertical and horizontal checks, the
// column and row division (only when a pixel is written) and the load into
// the output register. The pace is set by the shared 32x16 multiplier, which
// produces the ten period edges and tolerance products in turn, and by the
// shared restoring divider stage that yields one quotient bit a cycle for
// column and row. A finished result sits in the output register; the next
// sample is taken while it waits, and a second result waits in the sequencer
// until the first one leaves. A stalled result holds its value.
// Reset (rst_n low, synchronous) restores the default 640x480 timing,
// clears the line and frame times, the sync history and the flag sets.
module vga_sync_timing_check_capture import vstc_pkg::*; #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // samples
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_hsync,
  input  logic                 in_vsync,
  input  logic [2:0]           in_red_in,
  input  logic [2:0]           in_green_in,
  input  logic [2:0]           in_blue_in,
  input  logic [15:0]          in_elapsed_ns,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_frame_done,
  output logic [FLAG_W-1:0]    out_h_flags,
  output logic [FLAG_W-1:0]    out_v_flags,
  output logic                 out_pixel_write,
  output logic [9:0]           out_pixel_x,
  output logic [8:0]           out_pixel_y,
  output logic [7:0]           out_red_out,
  output logic [7:0]           out_green_out,
  output logic [7:0]           out_blue_out
);

  localparam int MAXD   = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int QW     = $clog2(MAXD + 1);
  localparam int QCNT_W = $clog2(QW + 1);
  localparam int DIV_W  = (LINE_W + QW > TIME_W) ? LINE_W + QW : TIME_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_VCHK = 3'd2;
  localparam logic [2:0] ST_HCHK = 3'd3;
  localparam logic [2:0] ST_DIVX = 3'd4;
  localparam logic [2:0] ST_DIVY = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // Multiplier steps
  localparam logic [3:0] M_H1   = 4'd0;
  localparam logic [3:0] M_H2   = 4'd1;
  localparam logic [3:0] M_H3   = 4'd2;
  localparam logic [3:0] M_H4   = 4'd3;
  localparam logic [3:0] M_V1   = 4'd4;
  localparam logic [3:0] M_V2   = 4'd5;
  localparam logic [3:0] M_V3   = 4'd6;
  localparam logic [3:0] M_V4   = 4'd7;
  localparam logic [3:0] M_VTOL = 4'd8;
  localparam logic [3:0] M_HTOL = 4'd9;
  localparam logic [3:0] M_LAST = 4'd10;

  // Configuration registers
  logic [7:0]        pixel_ns_r;
  logic [9:0]        h_sync_r, h_back_r, h_front_r;
  logic [9:0]        v_sync_r, v_back_r, v_front_r;
  logic [TOL_W-1:0]  tol_r;

  // Block state
  logic [TIME_W-1:0] line_time_r, frame_time_r;
  logic              hsync_prev_r, vsync_prev_r;
  logic [FLAG_W-1:0] h_acc_r, v_acc_r;

  // Per-item working registers
  logic [2:0]        state_r;
  logic [3:0]        step_r;
  logic              black_r;
  logic [2:0]        red_r, green_r, blue_r;
  logic              fd_r;
  logic [FLAG_W-1:0] hfo_r, vfo_r;
  logic [LINE_W-1:0] eh1_r, eh2_r, eh3_r, line_r;
  logic [SUM_W-1:0]  ev1_r, ev2_r, ev3_r, ev4_r;
  logic [MP_W-1:0]   htp_r, vtp_r;
  logic              y_ok_r;
  logic              wr_r;
  logic [DIV_W-1:0]  rem_r, dsh_r;
  logic [QW-1:0]     q_r, qx_r, qy_r;
  logic [QCNT_W-1:0] qcnt_r;

  // Output register
  logic              out_valid_r;
  logic              o_fd_r, o_wr_r;
  logic [FLAG_W-1:0] o_hf_r, o_vf_r;
  logic [9:0]        o_x_r;
  logic [8:0]        o_y_r;
  logic [7:0]        o_red_r, o_green_r, o_blue_r;

  logic              in_acc;
  logic              out_acc;
  logic              vfall, hfall;
  logic [TIME_W:0]   lt_sum, ft_sum;
  logic [TIME_W-1:0] lt_new, ft_new;
  logic [CNT_W-1:0]  hs1, hs2, hs3, hs4, vs1, vs2, vs3, vs4;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  phase_req_t        ph_req;
  logic [FLAG_W-1:0] ph_flags;
  logic              x_ok;
  logic [TIME_W-1:0] nx, ny;
  logic              div_ge;
  logic [QW-1:0]     q_nxt;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Saturating time update and sync edge detect at accept
  always_comb begin
    vfall  = vsync_prev_r && !in_vsync;
    hfall  = hsync_prev_r && !in_hsync;
    lt_sum = {1'b0, line_time_r} + (TIME_W + 1)'(in_elapsed_ns);
    ft_sum = {1'b0, frame_time_r} + (TIME_W + 1)'(in_elapsed_ns);
    lt_new = lt_sum[TIME_W] ? '1 : lt_sum[TIME_W-1:0];
    ft_new = ft_sum[TIME_W] ? '1 : ft_sum[TIME_W-1:0];
    if (hfall) lt_new = '0;
    if (vfall) ft_new = '0;
  end

  // Cumulative period counts
  always_comb begin
    hs1 = CNT_W'(h_sync_r);
    hs2 = hs1 + CNT_W'(h_back_r);
    hs3 = hs2 + CNT_W'(WIDTH);
    hs4 = hs3 + CNT_W'(h_front_r);
    vs1 = CNT_W'(v_sync_r);
    vs2 = vs1 + CNT_W'(v_back_r);
    vs3 = vs2 + CNT_W'(HEIGHT);
    vs4 = vs3 + CNT_W'(v_front_r);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      M_H1:   begin mul_a = MA_W'(hs1); mul_b = MB_W'(pixel_ns_r); end
      M_H2:   begin mul_a = MA_W'(hs2); mul_b = MB_W'(pixel_ns_r); end
      M_H3:   begin mul_a = MA_W'(hs3); mul_b = MB_W'(pixel_ns_r); end
      M_H4:   begin mul_a = MA_W'(hs4); mul_b = MB_W'(pixel_ns_r); end
      M_V1:   begin mul_a = MA_W'(mul_p[LINE_W-1:0]); mul_b = MB_W'(vs1); end
      M_V2:   begin mul_a = MA_W'(line_r); mul_b = MB_W'(vs2); end
      M_V3:   begin mul_a = MA_W'(line_r); mul_b = MB_W'(vs3); end
      M_V4:   begin mul_a = MA_W'(line_r); mul_b = MB_W'(vs4); end
      M_VTOL: begin mul_a = frame_time_r; mul_b = tol_r; end
      M_HTOL: begin mul_a = line_time_r; mul_b = tol_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  vstc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // Phase unit shared between the vertical and horizontal checks
  always_comb begin
    if (state_r == ST_HCHK) begin
      ph_req.sync  = hsync_prev_r;
      ph_req.black = black_r;
      ph_req.t     = line_time_r;
      ph_req.tp    = htp_r;
      ph_req.e1    = SUM_W'(eh1_r);
      ph_req.e2    = SUM_W'(eh2_r);
      ph_req.e3    = SUM_W'(eh3_r);
      ph_req.e4    = SUM_W'(line_r);
    end else begin
      ph_req.sync  = vsync_prev_r;
      ph_req.black = black_r;
      ph_req.t     = frame_time_r;
      ph_req.tp    = vtp_r;
      ph_req.e1    = ev1_r;
      ph_req.e2    = ev2_r;
      ph_req.e3    = ev3_r;
      ph_req.e4    = ev4_r;
    end
  end

  vstc_phase u_phase (
    .req   (ph_req),
    .flags (ph_flags)
  );

  // Visible-area tests and divider numerators
  always_comb begin
    x_ok = (pixel_ns_r != '0) && (line_time_r >= TIME_W'(eh2_r)) &&
           (line_time_r < TIME_W'(eh3_r));
    nx   = line_time_r - TIME_W'(eh2_r);
    ny   = frame_time_r - ev2_r[TIME_W-1:0];
  end

  // One restoring division step
  always_comb begin
    div_ge = (rem_r >= dsh_r);
    q_nxt  = (q_r << 1) | QW'(div_ge);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_ns_r <= 8'd40;
      h_sync_r   <= 10'd96;
      h_back_r   <= 10'd48;
      h_front_r  <= 10'd16;
      v_sync_r   <= 10'd2;
      v_back_r   <= 10'd33;
      v_front_r  <= 10'd10;
      tol_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIXEL_NS:      pixel_ns_r <= cfg_data[7:0];
        REG_H_SYNC_PX:     h_sync_r   <= cfg_data[9:0];
        REG_H_BACK_PX:     h_back_r   <= cfg_data[9:0];
        REG_H_FRONT_PX:    h_front_r  <= cfg_data[9:0];
        REG_V_SYNC_LINES:  v_sync_r   <= cfg_data[9:0];
        REG_V_BACK_LINES:  v_back_r   <= cfg_data[9:0];
        REG_V_FRONT_LINES: v_front_r  <= cfg_data[9:0];
        REG_TOLERANCE:     tol_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= M_H1;
      line_time_r  <= '0;
      frame_time_r <= '0;
      hsync_prev_r <= 1'b0;
      vsync_prev_r <= 1'b0;
      h_acc_r      <= '0;
      v_acc_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            line_time_r  <= lt_new;
            frame_time_r <= ft_new;
            hsync_prev_r <= in_hsync;
            vsync_prev_r <= in_vsync;
            if (vfall) begin
              h_acc_r <= '0;
              v_acc_r <= '0;
            end
            step_r  <= M_H1;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_r <= step_r + 4'd1;
          if (step_r == M_LAST) state_r <= ST_VCHK;
        end
        ST_VCHK: begin
          v_acc_r <= v_acc_r | ph_flags;
          state_r <= ST_HCHK;
        end
        ST_HCHK: begin
          h_acc_r <= h_acc_r | ph_flags;
          state_r <= (x_ok && y_ok_r) ? ST_DIVX : ST_OUT;
        end
        ST_DIVX: begin
          if (qcnt_r == '0) state_r <= ST_DIVY;
        end
        ST_DIVY: begin
          if (qcnt_r == '0) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Item payload and edge registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      black_r <= (in_red_in == '0) && (in_green_in == '0) && (in_blue_in == '0);
      red_r   <= in_red_in;
      green_r <= in_green_in;
      blue_r  <= in_blue_in;
      fd_r    <= vfall;
      hfo_r   <= vfall ? h_acc_r : '0;
      vfo_r   <= vfall ? v_acc_r : '0;
    end
    if (state_r == ST_MUL) begin
      case (step_r)
        M_H2:   eh1_r  <= mul_p[LINE_W-1:0];
        M_H3:   eh2_r  <= mul_p[LINE_W-1:0];
        M_H4:   eh3_r  <= mul_p[LINE_W-1:0];
        M_V1:   line_r <= mul_p[LINE_W-1:0];
        M_V2:   ev1_r  <= mul_p[SUM_W-1:0];
        M_V3:   ev2_r  <= mul_p[SUM_W-1:0];
        M_V4:   ev3_r  <= mul_p[SUM_W-1:0];
        M_VTOL: ev4_r  <= mul_p[SUM_W-1:0];
        M_HTOL: vtp_r  <= mul_p;
        M_LAST: htp_r  <= mul_p;
        default: ;
      endcase
    end
    if (state_r == ST_VCHK) begin
      y_ok_r <= ({2'b0, frame_time_r} >= ev2_r) && ({2'b0, frame_time_r} < ev3_r);
    end
    if (state_r == ST_HCHK) begin
      wr_r   <= x_ok && y_ok_r;
      rem_r  <= DIV_W'(nx);
      dsh_r  <= DIV_W'(pixel_ns_r) << (QW - 1);
      q_r    <= '0;
      qcnt_r <= QCNT_W'(QW - 1);
      qx_r   <= '0;
      qy_r   <= '0;
    end
    // column then row, one quotient bit per cycle
    if (state_r == ST_DIVX || state_r == ST_DIVY) begin
      if (qcnt_r == '0) begin
        rem_r  <= DIV_W'(ny);
        dsh_r  <= DIV_W'(line_r) << (QW - 1);
        q_r    <= '0;
        qcnt_r <= QCNT_W'(QW - 1);
        if (state_r == ST_DIVX) qx_r <= q_nxt;
        else                    qy_r <= q_nxt;
      end else begin
        if (div_ge) rem_r <= rem_r - dsh_r;
        dsh_r  <= dsh_r >> 1;
        q_r    <= q_nxt;
        qcnt_r <= qcnt_r - QCNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_fd_r    <= fd_r;
      o_hf_r    <= hfo_r;
      o_vf_r    <= vfo_r;
      o_wr_r    <= wr_r;
      o_x_r     <= wr_r ? 10'(qx_r) : '0;
      o_y_r     <= wr_r ? 9'(qy_r) : '0;
      o_red_r   <= wr_r ? {red_r, 5'b0} : '0;
      o_green_r <= wr_r ? {green_r, 5'b0} : '0;
      o_blue_r  <= wr_r ? {blue_r, 5'b0} : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_done  = o_fd_r;
  assign out_h_flags     = o_hf_r;
  assign out_v_flags     = o_vf_r;
  assign out_pixel_write = o_wr_r;
  assign out_pixel_x     = o_x_r;
  assign out_pixel_y     = o_y_r;
  assign out_red_out     = o_red_r;
  assign out_green_out   = o_green_r;
  assign out_blue_out    = o_blue_r;

`ifndef NO_ASSERTIONS
  // a sample is never taken twice in a row
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("sample accepted while previous one in flight");

  // written pixels lie inside the active area
  a_pixel_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_write) |->
      (32'(out_pixel_x) < WIDTH) && (32'(out_pixel_y) < HEIGHT))
    else $error("pixel write outside active area");

  // no pixel write means empty pixel fields
  a_pixel_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_write) |->
      (out_pixel_x == '0) && (out_pixel_y == '0) && (out_red_out == '0) &&
      (out_green_out == '0) && (out_blue_out == '0))
    else $error("pixel fields set without pixel write");

  // flag report only at the end of a frame
  a_flags_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_done) |-> (out_h_flags == '0) && (out_v_flags == '0))
    else $error("flags reported without frame end");
`endif

endmodule

/* dv/vga_sync_timing_check_capture_test.sv */
`timescale 1ns / 100ps

module vga_sync_timing_check_capture_test import vstc_pkg::*; ();

  localparam int VIS_W          = 640;
  localparam int VIS_H          = 480;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SAT_ITEMS      = 20;
  // index past the last register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd15;

  typedef struct packed {
    logic        hsync;
    logic        vsync;
    logic [2:0]  red;
    logic [2:0]  green;
    logic [2:0]  blue;
    logic [15:0] elapsed;
  } sample_t;

  typedef struct packed {
    logic              frame_done;
    logic [FLAG_W-1:0] h_flags;
    logic [FLAG_W-1:0] v_flags;
    logic              pixel_write;
    logic [9:0]        x;
    logic [8:0]        y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } capture_t;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    sample_t              smp;
    logic                 typed;
    capture_t             want;
  } row_t;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [15:0]          cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_hsync      = 1'b0;
  logic                 in_vsync      = 1'b0;
  logic [2:0]           in_red_in     = '0;
  logic [2:0]           in_green_in   = '0;
  logic [2:0]           in_blue_in    = '0;
  logic [15:0]          in_elapsed_ns = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_frame_done;
  logic [FLAG_W-1:0]    out_h_flags;
  logic [FLAG_W-1:0]    out_v_flags;
  logic                 out_pixel_write;
  logic [9:0]           out_pixel_x;
  logic [8:0]           out_pixel_y;
  logic [7:0]           out_red_out;
  logic [7:0]           out_green_out;
  logic [7:0]           out_blue_out;

  vga_sync_timing_check_capture #(
    .WIDTH (VIS_W),
    .HEIGHT(VIS_H)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_hsync       (in_hsync),
    .in_vsync       (in_vsync),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_elapsed_ns  (in_elapsed_ns),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_done (out_frame_done),
    .out_h_flags    (out_h_flags),
    .out_v_flags    (out_v_flags),
    .out_pixel_write(out_pixel_write),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

  // Timing registers as the block should hold them
  logic [7:0]        m_pixel_ns;
  logic [9:0]        m_h_sync, m_h_back, m_h_front;
  logic [9:0]        m_v_sync, m_v_back, m_v_front;
  logic [15:0]       m_tol;
  // Scan state as the block should hold it
  logic [31:0]       m_line_time, m_frame_time;
  logic              m_hs_prev, m_vs_prev;
  logic [FLAG_W-1:0] m_h_acc, m_v_acc;

  // Ideal beam position used to build well-formed sample streams
  longint unsigned   beam_lt, beam_ft;

  capture_t          pending[$];
  row_t              dir_rows[$];
  int                fails       = 0;
  int                idle_cycles = 0;
  int                stall_left  = 0;
  bit                calm        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_reset();
    m_pixel_ns = 8'd40;
    m_h_sync = 10'd96; m_h_back = 10'd48; m_h_front = 10'd16;
    m_v_sync = 10'd2;  m_v_back = 10'd33; m_v_front = 10'd10;
    m_tol = '0;
    m_line_time = '0; m_frame_time = '0;
    m_hs_prev = 1'b0; m_vs_prev = 1'b0;
    m_h_acc = '0; m_v_acc = '0;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      REG_PIXEL_NS:      m_pixel_ns = data[7:0];
      REG_H_SYNC_PX:     m_h_sync   = data[9:0];
      REG_H_BACK_PX:     m_h_back   = data[9:0];
      REG_H_FRONT_PX:    m_h_front  = data[9:0];
      REG_V_SYNC_LINES:  m_v_sync   = data[9:0];
      REG_V_BACK_LINES:  m_v_back   = data[9:0];
      REG_V_FRONT_LINES: m_v_front  = data[9:0];
      REG_TOLERANCE:     m_tol      = data;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + 33'(b);
    return sum[32] ? '1 : sum[31:0];
  endfunction

  // Sort time t into a phase, with tolerance widening the test, and flag misbehavior
  function automatic logic [FLAG_W-1:0] phase_flags(logic sync, logic black, logic [31:0] t,
                                                    logic [63:0] s, logic [63:0] b,
                                                    logic [63:0] a, logic [63:0] f);
    logic [63:0]       hi, lo, e1, e2, e3, e4;
    logic [FLAG_W-1:0] fl;
    hi = 64'(t) * (64'd65536 + 64'(m_tol));
    lo = 64'(t) * (64'd65536 - 64'(m_tol));
    e1 = s << 16;
    e2 = (s + b) << 16;
    e3 = (s + b + a) << 16;
    e4 = (s + b + a + f) << 16;
    fl = '0;
    if (hi < e1) begin
      fl[F_SYNC_HI_PULSE] = sync;
      fl[F_BLACK_PULSE]   = black;
    end else if (hi < e2) begin
      fl[F_SYNC_LO_BACK] = !sync;
      fl[F_BLACK_BACK]   = black;
    end else if (lo > e2 && hi < e3) begin
      fl[F_SYNC_LO_ACTIVE] = !sync;
    end else if (lo > e3 && hi < e4) begin
      fl[F_SYNC_LO_FRONT] = !sync;
      fl[F_BLACK_FRONT]   = black;
    end
    return fl;
  endfunction

  // Advance the scan state by one sample and return the capture it should produce
  function automatic capture_t predict_capture(sample_t s);
    logic [63:0] p, hsp, hbp, hva, hfp, line_ns, vsp, vbp, vva, vfp, x, y;
    logic        black;
    capture_t    c;
    c = '0;
    black = (s.red == 3'd0) && (s.green == 3'd0) && (s.blue == 3'd0);
    p       = 64'(m_pixel_ns);
    hsp     = 64'(m_h_sync) * p;
    hbp     = 64'(m_h_back) * p;
    hva     = 64'(VIS_W) * p;
    hfp     = 64'(m_h_front) * p;
    line_ns = hsp + hbp + hva + hfp;
    vsp     = 64'(m_v_sync) * line_ns;
    vbp     = 64'(m_v_back) * line_ns;
    vva     = 64'(VIS_H) * line_ns;
    vfp     = 64'(m_v_front) * line_ns;

    m_line_time  = add_sat(m_line_time, s.elapsed);
    m_frame_time = add_sat(m_frame_time, s.elapsed);

    // falling vsync closes the frame report
    if (m_vs_prev && !s.vsync) begin
      m_frame_time = '0;
      c.frame_done = 1'b1;
      c.h_flags    = m_h_acc;
      c.v_flags    = m_v_acc;
      m_h_acc      = '0;
      m_v_acc      = '0;
    end
    m_v_acc |= phase_flags(s.vsync, black, m_frame_time, vsp, vbp, vva, vfp);

    if (m_hs_prev && !s.hsync) m_line_time = '0;
    m_h_acc |= phase_flags(s.hsync, black, m_line_time, hsp, hbp, hva, hfp);

    // pixel position only once past both sync and back porch
    if (p != 0 && line_ns != 0 && 64'(m_line_time) >= hsp + hbp &&
        64'(m_frame_time) >= vsp + vbp) begin
      x = (64'(m_line_time) - hsp - hbp) / p;
      y = (64'(m_frame_time) - vsp - vbp) / line_ns;
      if (x < 64'(VIS_W) && y < 64'(VIS_H)) begin
        c.pixel_write = 1'b1;
        c.x           = x[9:0];
        c.y           = y[8:0];
        c.red         = {s.red, 5'b0};
        c.green       = {s.green, 5'b0};
        c.blue        = {s.blue, 5'b0};
      end
    end

    m_hs_prev = s.hsync;
    m_vs_prev = s.vsync;
    return c;
  endfunction

  function automatic sample_t mk_sample(logic hs, logic vs, logic [2:0] r, logic [2:0] g,
                                        logic [2:0] b, logic [15:0] el);
    sample_t s;
    s.hsync = hs; s.vsync = vs;
    s.red = r; s.green = g; s.blue = b;
    s.elapsed = el;
    return s;
  endfunction

  // Next sample of a well-formed scan at the current timing, or noise now and then
  function automatic sample_t beam_sample();
    longint unsigned p, hsp, hbp, hva, line_ns, vsp, vbp, vva, frame_ns, el;
    sample_t         s;
    bit              visible;
    s = sample_t'($urandom);
    p        = m_pixel_ns;
    hsp      = m_h_sync * p;
    hbp      = m_h_back * p;
    hva      = VIS_W * p;
    line_ns  = hsp + hbp + hva + m_h_front * p;
    vsp      = m_v_sync * line_ns;
    vbp      = m_v_back * line_ns;
    vva      = VIS_H * line_ns;
    frame_ns = vsp + vbp + vva + m_v_front * line_ns;
    if (line_ns == 0 || $urandom_range(0, 99) < 15) return s;
    case ($urandom_range(0, 3))
      0, 1:    el = $urandom_range(0, 32'(line_ns / 4) + 1);
      2:       el = $urandom_range(0, 32'(line_ns * 2));
      default: el = $urandom_range(0, 65535);
    endcase
    if (el > 65535) el = 65535;
    beam_lt   = (beam_lt + el) % line_ns;
    beam_ft   = (beam_ft + el) % frame_ns;
    s.elapsed = el[15:0];
    // sync pulses are active low
    s.hsync   = beam_lt >= hsp;
    s.vsync   = beam_ft >= vsp;
    visible   = beam_lt >= hsp + hbp && beam_lt < hsp + hbp + hva &&
                beam_ft >= vsp + vbp && beam_ft < vsp + vbp + vva;
    // blanking is black, apart from the odd bad sample
    if (!visible && $urandom_range(0, 9) != 0) begin
      s.red = '0; s.green = '0; s.blue = '0;
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (calm || r < 7) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic row_t srow(logic hs, logic vs, logic [2:0] r, logic [2:0] g,
                                logic [2:0] b, logic [15:0] el);
    row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.smp  = mk_sample(hs, vs, r, g, b, el);
    return row;
  endfunction

  function automatic row_t rrow(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic row_t known(row_t row, capture_t want);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Directed stimulus; only the first rows carry a hand-written capture
  function automatic void build_table();
    capture_t rep;
    rep = '0;
    rep.frame_done = 1'b1;
    rep.h_flags = FLAG_W'((1 << F_SYNC_HI_PULSE) | (1 << F_BLACK_PULSE));
    rep.v_flags = FLAG_W'((1 << F_SYNC_HI_PULSE) | (1 << F_BLACK_PULSE));
    // straight after reset: nothing visible, nothing reported
    dir_rows.push_back(known(srow(0, 0, 7, 7, 7, 0), '0));
    // syncs high and black inside both pulses
    dir_rows.push_back(known(srow(1, 1, 0, 0, 0, 0), '0));
    // falling vsync reports those two flags on both axes
    dir_rows.push_back(known(srow(1, 0, 7, 7, 7, 0), rep));
    dir_rows.push_back(rrow(REG_NONE, 16'hFFFF));
    dir_rows.push_back(srow(1, 1, 7, 0, 7, 16'hFFFF));
    dir_rows.push_back(srow(0, 1, 0, 7, 0, 16'hFFFF));
    // no porches, one ns per pixel: pixel position equals elapsed time
    dir_rows.push_back(rrow(REG_PIXEL_NS, 16'd1));
    dir_rows.push_back(rrow(REG_H_SYNC_PX, 16'd0));
    dir_rows.push_back(rrow(REG_H_BACK_PX, 16'd0));
    dir_rows.push_back(rrow(REG_H_FRONT_PX, 16'd0));
    dir_rows.push_back(rrow(REG_V_SYNC_LINES, 16'd0));
    dir_rows.push_back(rrow(REG_V_BACK_LINES, 16'd0));
    dir_rows.push_back(rrow(REG_V_FRONT_LINES, 16'd0));
    dir_rows.push_back(srow(1, 1, 7, 7, 7, 0));
    dir_rows.push_back(srow(0, 0, 7, 5, 3, 0));
    dir_rows.push_back(srow(0, 0, 1, 2, 4, 16'd639));
    dir_rows.push_back(srow(0, 0, 7, 7, 7, 16'd1));
    for (int i = 0; i < 4; i++) dir_rows.push_back(srow(1, 0, 0, 0, 0, 16'hFFFF));
    // last visible row, then one past it
    dir_rows.push_back(srow(0, 0, 6, 6, 6, 16'd43780));
    dir_rows.push_back(srow(0, 0, 0, 0, 0, 16'd640));
    // widest tolerance and longest periods
    dir_rows.push_back(rrow(REG_TOLERANCE, 16'hFFFF));
    dir_rows.push_back(rrow(REG_PIXEL_NS, 16'd255));
    dir_rows.push_back(rrow(REG_H_SYNC_PX, 16'd1023));
    dir_rows.push_back(rrow(REG_V_BACK_LINES, 16'd1023));
    dir_rows.push_back(srow(1, 1, 7, 7, 7, 16'hFFFF));
    dir_rows.push_back(srow(0, 1, 0, 0, 0, 16'd1000));
    dir_rows.push_back(srow(1, 1, 3, 3, 3, 16'hFFFF));
    // zero pixel period suppresses pixel writes
    dir_rows.push_back(rrow(REG_TOLERANCE, 16'd0));
    dir_rows.push_back(rrow(REG_PIXEL_NS, 16'd0));
    dir_rows.push_back(srow(1, 1, 7, 7, 7, 16'd100));
    dir_rows.push_back(srow(0, 0, 7, 7, 7, 16'd100));
  endfunction

  task automatic match(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  task automatic check_capture(capture_t want);
    match("frame_done", 32'(want.frame_done), 32'(out_frame_done));
    match("h_flags", 32'(want.h_flags), 32'(out_h_flags));
    match("v_flags", 32'(want.v_flags), 32'(out_v_flags));
    match("pixel_write", 32'(want.pixel_write), 32'(out_pixel_write));
    match("pixel_x", 32'(want.x), 32'(out_pixel_x));
    match("pixel_y", 32'(want.y), 32'(out_pixel_y));
    match("red_out", 32'(want.red), 32'(out_red_out));
    match("green_out", 32'(want.green), 32'(out_green_out));
    match("blue_out", 32'(want.blue), 32'(out_blue_out));
  endtask

  // Offer one item, wait for it to be taken, then log what it should produce
  task automatic push_sample(sample_t s, logic typed, capture_t want);
    int       gap;
    capture_t guess;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hsync      <= s.hsync;
    in_vsync      <= s.vsync;
    in_red_in     <= s.red;
    in_green_in   <= s.green;
    in_blue_in    <= s.blue;
    in_elapsed_ns <= s.elapsed;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    guess = predict_capture(s);
    pending.push_back(typed ? want : guess);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    model_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_timing(logic [7:0] p, logic [9:0] hs, logic [9:0] hb, logic [9:0] hf,
                              logic [9:0] vs, logic [9:0] vb, logic [9:0] vf,
                              logic [15:0] tol);
    wait_idle();
    write_reg(REG_PIXEL_NS, 16'(p));
    write_reg(REG_H_SYNC_PX, 16'(hs));
    write_reg(REG_H_BACK_PX, 16'(hb));
    write_reg(REG_H_FRONT_PX, 16'(hf));
    write_reg(REG_V_SYNC_LINES, 16'(vs));
    write_reg(REG_V_BACK_LINES, 16'(vb));
    write_reg(REG_V_FRONT_LINES, 16'(vf));
    write_reg(REG_TOLERANCE, tol);
    beam_lt = 0;
    beam_ft = 0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // switch between bursty and back-to-back traffic now and then
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      push_sample(beam_sample(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  // Result side: check each accepted capture and stall at random
  always @(posedge clk) begin
    capture_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending.size() == 0) begin
        $error("capture result with no sample pending");
        fails++;
      end else begin
        want = pending.pop_front();
        check_capture(want);
      end
    end
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Watchdog on cycles where no channel moves anything
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    build_table();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // standard 640x480 timing, then small, largest, empty and odd timings
    apply_timing(8'd40, 10'd96, 10'd48, 10'd16, 10'd2, 10'd33, 10'd10,
                 16'($urandom_range(0, 4000)));
    run_random(180);
    apply_timing(8'd1, 10'd8, 10'd4, 10'd2, 10'd1, 10'd2, 10'd1,
                 16'($urandom_range(0, 2000)));
    run_random(180);
    apply_timing(8'd255, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                 16'hFFFF);
    run_random(60);
    apply_timing(8'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 16'd0);
    run_random(60);
    apply_timing(8'd3, 10'($urandom_range(0, 40)), 10'($urandom_range(0, 40)),
                 10'($urandom_range(0, 40)), 10'($urandom_range(0, 5)),
                 10'($urandom_range(0, 5)), 10'($urandom_range(0, 5)),
                 16'($urandom_range(0, 65535)));
    run_random(180);
    apply_timing(8'd2, 10'd96, 10'd48, 10'd16, 10'd2, 10'd33, 10'd10, 16'd3000);
    run_random(150);

    // hold both syncs high at the longest step, well past a full line
    apply_timing(8'd40, 10'd96, 10'd48, 10'd16, 10'd2, 10'd33, 10'd10, 16'd0);
    calm = 1'b1;
    for (int i = 0; i < SAT_ITEMS; i++)
      push_sample(mk_sample(1, 1, 3'($urandom), 3'($urandom), 3'($urandom), 16'hFFFF),
                  1'b0, '0);
    calm = 1'b0;
    push_sample(mk_sample(0, 1, 7, 7, 7, 16'd5), 1'b0, '0);
    push_sample(mk_sample(0, 0, 0, 0, 0, 16'd5), 1'b0, '0);

    wait_idle();
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/vstc_pkg.sv
hdl/vstc_mul.sv
hdl/vstc_phase.sv
hdl/vga_sync_timing_check_capture.sv
dv/vga_sync_timing_check_capture_test.sv
